### hw/rtl/sap_pkg.sv
// Shared types, constants and helpers for the stack allocator with padding header.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package sap_pkg;

	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 32;
	localparam int OFF_W       = 13;
	localparam int ALIGN_W     = 8;
	localparam int PAD_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int DEFAULT_ALIGN = 16;
	localparam int MAX_ALIGN   = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_RESIZE = 2'd1,
		CMD_FREE   = 2'd2,
		CMD_RESET  = 2'd3
	} sap_cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADARG   = 2'd1,
		ST_BADSTATE = 2'd2,
		ST_NOMEM    = 2'd3
	} sap_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 1'd0,
		REG_CAPACITY     = 1'd1
	} sap_reg_t;

	// What the back end has to do with a classified item
	typedef enum logic [2:0] {
		OP_REPLY  = 3'd0,	// fixed status, no state change
		OP_RESET  = 3'd1,
		OP_ALLOC  = 3'd2,
		OP_FREE   = 3'd3,
		OP_RESIZE = 3'd4
	} sap_kind_t;

	typedef struct packed {
		sap_kind_t            kind;
		sap_status_t          status;
		logic [OFF_W-1:0]     rel;	// block offset inside the buffer
		logic [SIZE_W-1:0]    size;
		logic [ADDR_W-1:0]    addr;
		logic [ALIGN_W-1:0]   al;
		logic                 keep;	// resize may return the same block
	} sap_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sap_qstat_t;

	// 0 selects the default, large values clamp, non powers of two give 0
	function automatic logic [ALIGN_W-1:0] norm_align(input logic [ALIGN_W-1:0] a);
		logic [ALIGN_W-1:0] n;
		n = a;
		if (a == '0)
			n = ALIGN_W'(DEFAULT_ALIGN);
		else if (a > ALIGN_W'(MAX_ALIGN))
			n = ALIGN_W'(MAX_ALIGN);
		if ((n & (n - ALIGN_W'(1))) != '0)
			n = '0;
		return n;
	endfunction

endpackage

### hw/rtl/sap_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on sap_pkg for field widths.
`timescale 1ns / 1ps

interface sap_req_if import sap_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           cmd;
	logic [SIZE_W-1:0]    req_size;
	logic [SIZE_W-1:0]    prev_size;
	logic [ALIGN_W-1:0]   align_req;
	logic [ADDR_W-1:0]    block_address;

	modport source (output valid, cmd, req_size, prev_size, align_req, block_address,
		input ready);
	modport sink (input valid, cmd, req_size, prev_size, align_req, block_address,
		output ready);
endinterface

interface sap_rsp_if import sap_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [ADDR_W-1:0]    result_address;
	logic [SIZE_W-1:0]    result_size;
	logic                 moved;
	logic [OFF_W-1:0]     peak_bytes;

	modport source (output valid, status, result_address, result_size, moved, peak_bytes,
		input ready);
	modport sink (input valid, status, result_address, result_size, moved, peak_bytes,
		output ready);
endinterface

### hw/rtl/sap_front.sv
// Front end: accepts request items and classifies everything that does not
// depend on the top offset. Depends on sap_pkg and sap_if.
`timescale 1ns / 1ps

module sap_front import sap_pkg::*; (
	sap_req_if.sink            req,
	input  logic [ADDR_W-1:0]  base_address,
	input  logic [OFF_W-1:0]   cap,
	input  sap_qstat_t         qstat,
	output logic               push,
	output sap_op_t            op
);

	logic [ADDR_W-1:0]  rel_full;
	logic               in_buf;
	logic [ALIGN_W-1:0] al;
	logic               keep;

	assign req.ready = !qstat.full;
	assign push      = req.valid && req.ready;

	assign rel_full = req.block_address - base_address;
	assign in_buf   = rel_full < ADDR_W'(cap);
	assign al       = norm_align(req.align_req);
	assign keep     = ((req.block_address[ALIGN_W-1:0] & (al - ALIGN_W'(1))) == '0) &&
		(req.prev_size == req.req_size);

	always_comb begin
		op        = '0;
		op.kind   = OP_REPLY;
		op.status = ST_OK;
		op.rel    = rel_full[OFF_W-1:0];
		op.size   = req.req_size;
		op.addr   = req.block_address;
		op.al     = al;
		op.keep   = keep;
		if (req.cmd == CMD_RESET) begin
			op.kind = OP_RESET;
		end else if (base_address == '0) begin
			op.status = ST_BADSTATE;
		end else if (req.cmd == CMD_FREE) begin
			if (req.block_address == '0)
				op.status = ST_OK;
			else if (!in_buf)
				op.status = ST_BADARG;
			else
				op.kind = OP_FREE;
		end else if (al == '0) begin
			op.status = ST_BADARG;
		end else if (req.cmd == CMD_ALLOC || req.block_address == '0) begin
			// null block in resize acts as a plain alloc
			if (req.req_size != '0)
				op.kind = OP_ALLOC;
		end else if (req.req_size == '0) begin
			// resize to zero frees the block
			if (!in_buf)
				op.status = ST_BADARG;
			else
				op.kind = OP_FREE;
		end else if (!in_buf) begin
			op.status = ST_BADARG;
		end else begin
			op.kind = OP_RESIZE;
		end
	end

endmodule

### hw/rtl/sap_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on sap_pkg.
`timescale 1ns / 1ps

module sap_queue import sap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sap_op_t     push_op,
	input  logic        pop,
	output sap_op_t     head,
	output sap_qstat_t  qstat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sap_op_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

### hw/rtl/sap_back.sv
// Back end: owns top/peak offsets and the padding store, executes one item
// at a time and holds the result register. Depends on sap_pkg and sap_if.
`timescale 1ns / 1ps

module sap_back import sap_pkg::*; #(
	parameter int BUFFER_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ADDR_W-1:0]  base_address,
	input  logic [OFF_W-1:0]   cap,
	input  sap_qstat_t         qstat,
	input  sap_op_t            head,
	output logic               pop,
	sap_rsp_if.source          rsp
);

	localparam int IDX_W  = $clog2(BUFFER_BYTES);
	localparam int NEED_W = SIZE_W + 2;

	typedef enum logic {B_IDLE, B_EXEC} state_t;

	state_t             state_q;
	logic [OFF_W-1:0]   top_q;
	logic [OFF_W-1:0]   peak_q;
	logic               out_valid_q;
	sap_status_t        status_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [SIZE_W-1:0]  size_q;
	logic               moved_q;

	sap_op_t            op_s1;
	logic [ADDR_W-1:0]  cur_s1;
	logic [PAD_W-1:0]   pad_s1;
	logic [PAD_W-1:0]   pad_rd_s1;

	logic [PAD_W-1:0]   pad_mem [BUFFER_BYTES];

	logic               commit;
	logic [ADDR_W-1:0]  cur_nx;
	logic [PAD_W-1:0]   pad_nx;
	logic [IDX_W-1:0]   rd_idx_w;
	logic [IDX_W-1:0]   wr_idx_w;
	logic [NEED_W-1:0]  need;
	logic               nomem;
	logic [ADDR_W-1:0]  user;
	logic               rel_hi;
	logic [OFF_W-1:0]   free_top;
	logic               do_alloc;
	logic               alloc_moved;
	logic               wr_en;
	sap_status_t        res_status;
	logic [ADDR_W-1:0]  res_addr;
	logic [SIZE_W-1:0]  res_size;
	logic               res_moved;
	logic [OFF_W-1:0]   top_nx;
	logic [OFF_W-1:0]   peak_nx;

	assign pop    = (state_q == B_IDLE) && !qstat.empty;
	assign commit = (state_q == B_EXEC) && (!out_valid_q || rsp.ready);

	// at pop: cursor, padding to the next boundary, padding byte read
	assign cur_nx   = base_address + ADDR_W'(top_q);
	assign pad_nx   = head.al - (cur_nx[ALIGN_W-1:0] & (head.al - ALIGN_W'(1)));
	assign rd_idx_w = IDX_W'(head.rel) - IDX_W'(1);

	// in B_EXEC: capacity check and commit
	assign need     = NEED_W'(top_q) + NEED_W'(pad_s1) + NEED_W'(op_s1.size);
	assign nomem    = need > NEED_W'(cap);
	assign user     = cur_s1 + ADDR_W'(pad_s1);
	assign rel_hi   = op_s1.rel >= top_q;
	assign wr_idx_w = IDX_W'(top_q) + IDX_W'(pad_s1) - IDX_W'(1);
	// block at the buffer start, or padding larger than the offset: top drops to 0
	assign free_top = (op_s1.rel == '0 || OFF_W'(pad_rd_s1) > op_s1.rel) ? '0 :
		op_s1.rel - OFF_W'(pad_rd_s1);

	always_comb begin
		do_alloc    = 1'b0;
		alloc_moved = 1'b0;
		wr_en       = 1'b0;
		res_status  = ST_OK;
		res_addr    = '0;
		res_size    = '0;
		res_moved   = 1'b0;
		top_nx      = top_q;
		case (op_s1.kind)
			OP_RESET: begin
				top_nx = '0;
			end
			OP_ALLOC: begin
				do_alloc = 1'b1;
			end
			OP_FREE: begin
				if (!rel_hi)
					top_nx = free_top;
			end
			OP_RESIZE: begin
				if (!rel_hi) begin
					if (op_s1.keep) begin
						res_addr = op_s1.addr;
						res_size = op_s1.size;
					end else begin
						do_alloc    = 1'b1;
						alloc_moved = 1'b1;
					end
				end
			end
			default: begin
				res_status = op_s1.status;
			end
		endcase
		if (do_alloc) begin
			if (nomem) begin
				res_status = ST_NOMEM;
			end else begin
				res_addr  = user;
				res_size  = op_s1.size;
				res_moved = alloc_moved;
				top_nx    = need[OFF_W-1:0];
				wr_en     = 1'b1;
			end
		end
		peak_nx = (wr_en && top_nx > peak_q) ? top_nx : peak_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1     <= head;
			cur_s1    <= cur_nx;
			pad_s1    <= pad_nx;
			pad_rd_s1 <= pad_mem[rd_idx_w];
		end
		if (commit && wr_en)
			pad_mem[wr_idx_w] <= pad_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			top_q       <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			addr_q      <= '0;
			size_q      <= '0;
			moved_q     <= 1'b0;
		end else begin
			// a commit may reload the result register in the cycle it drains
			if (commit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop)
						state_q <= B_EXEC;
				end
				B_EXEC: begin
					if (commit) begin
						state_q     <= B_IDLE;
						top_q       <= top_nx;
						peak_q      <= peak_nx;
						status_q    <= res_status;
						addr_q      <= res_addr;
						size_q      <= res_size;
						moved_q     <= res_moved;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// peak only changes at a commit, which also reloads the result register
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.result_address = addr_q;
	assign rsp.result_size    = size_q;
	assign rsp.moved          = moved_q;
	assign rsp.peak_bytes     = peak_q;

endmodule

### hw/rtl/stack_allocator_padding_header.sv
// Stack allocator with a one-byte padding header: top level with config registers.
// Depends on sap_pkg, sap_if, sap_front, sap_queue and sap_back.
`timescale 1ns / 1ps
//
//  channel  direction  handshake          payload
//  req      in         req.valid/ready    cmd, req_size, prev_size, align_req, block_address
//  rsp      out        rsp.valid/ready    status, result_address, result_size, moved, peak_bytes
//  cfg      in         cfg_we (no ready)  cfg_index, cfg_data
//
//  In the back end each item first forms the cursor and padding and reads the
//  padding store, then gets the capacity check and the offset update.
//  The front end queues up to 2 classified items; req drops ready once the queue
//  is full behind a busy back end. A held result blocks only the commit step.
//  arst_n clears offsets, queue and handshake state; the padding store is not cleared.

module stack_allocator_padding_header import sap_pkg::*; #(
	parameter int BUFFER_BYTES = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	sap_req_if.sink                req,
	sap_rsp_if.source              rsp
);

	logic [ADDR_W-1:0]  base_address_q;
	logic [OFF_W-1:0]   capacity_q;
	logic [OFF_W-1:0]   cap;

	logic               push;
	logic               pop;
	sap_op_t            push_op;
	sap_op_t            head;
	sap_qstat_t         qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			capacity_q     <= '0;
		end else if (cfg_we) begin
			case (sap_reg_t'(cfg_index))
				REG_BASE_ADDRESS: base_address_q <= cfg_data[ADDR_W-1:0];
				REG_CAPACITY:     capacity_q     <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// usable size never exceeds the store
	assign cap = (ADDR_W'(capacity_q) > ADDR_W'(BUFFER_BYTES)) ? OFF_W'(BUFFER_BYTES) :
		capacity_q;

	sap_front u_front (
		.req          (req),
		.base_address (base_address_q),
		.cap          (cap),
		.qstat        (qstat),
		.push         (push),
		.op           (push_op)
	);

	sap_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	sap_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_address_q),
		.cap          (cap),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.rsp          (rsp)
	);

endmodule

### hw/rtl/sap_checker.sv
// Port-level checks on the response channel of the allocator, bound to the top.
// Depends on sap_pkg and stack_allocator_padding_header.
`timescale 1ns / 1ps

module sap_checker import sap_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [1:0]         rsp_status,
	input logic [ADDR_W-1:0]  rsp_result_address,
	input logic [SIZE_W-1:0]  rsp_result_size,
	input logic               rsp_moved
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp item dropped while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("rsp valid right after reset");

	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
			rsp_result_address == '0 && rsp_result_size == '0 && !rsp_moved)
		else $error("failed request returned a block");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_moved |-> rsp_status == ST_OK && rsp_result_size != '0)
		else $error("moved set without a new block");

endmodule

bind stack_allocator_padding_header sap_checker u_sap_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_result_address (rsp.result_address),
	.rsp_result_size    (rsp.result_size),
	.rsp_moved          (rsp.moved)
);
